FILE: rtl/fir64_pkg.sv
// Package: shared widths, types and defaults for the 64-tap FIR filter.
`timescale 1ns / 1ps

package fir64_pkg;

    localparam int TAPS_DEF = 64;   // default tap count
    localparam int IDX_W    = 6;    // width of the coefficient index field
    localparam int SMP_W    = 16;   // Q1.15 sample and coefficient width
    localparam int PROD_W   = 2 * SMP_W;
    localparam int ACC_W    = 40;   // Q10.30 result width

    typedef logic signed [SMP_W-1:0]  t_smp;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_FILTER = 1'b1;

endpackage

FILE: rtl/fir64_if.sv
// Interfaces: input word channel and result word channel of the FIR filter.
`timescale 1ns / 1ps

interface fir64_in_if;
    import fir64_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [IDX_W-1:0]  coef_index;
    t_smp              coef_value;
    t_smp              sample;

    modport source (output valid, output cmd, output coef_index, output coef_value,
                    output sample, input ready);
    modport sink   (input valid, input cmd, input coef_index, input coef_value,
                    input sample, output ready);
endinterface

interface fir64_out_if;
    import fir64_pkg::*;

    logic valid;
    logic ready;
    t_acc filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

FILE: rtl/fir_filter_64tap.sv
// Top level: direct-form FIR filter, one shared multiply-accumulate over all taps.
// Ready only while idle: no new sample word or coefficient load is accepted until
//   the single MAC has walked all TAPS coefficient/delay pairs and the sum has
//   moved to the output register.
// Reset (i_rst_n low, synchronous): sequencer idle, no result pending, delay
//   line and coefficient store read as zero at once through per-entry valid bits.
`timescale 1ns / 1ps

module fir_filter_64tap #(
    parameter int TAPS = fir64_pkg::TAPS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fir64_in_if.sink        i_in,
    fir64_out_if.source     o_out
);
    import fir64_pkg::*;

    // address width of both stores; index compare width holds TAPS itself
    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int IW = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DONE
    } t_state;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state           r_state;
    logic [AW-1:0]    r_wptr;       // slot that takes the next sample
    logic [AW-1:0]    r_rptr;       // delay slot read for the current tap
    logic [AW-1:0]    r_k;          // coefficient index of the current tap
    logic             r_issue;      // reads still being issued
    logic             r_p1;         // read data valid stage
    logic             r_p2;         // product valid stage
    t_prod            r_prod;
    t_acc             r_acc;
    logic             r_out_valid;
    t_acc             r_filtered;

    logic [TAPS-1:0]  r_dl_vld;     // delay slot written since reset
    logic [TAPS-1:0]  r_cf_vld;     // coefficient written since reset
    logic             r_dl_rd_vld;
    logic             r_cf_rd_vld;

    // memories, read data registered
    t_smp             m_dl [TAPS];
    t_smp             m_cf [TAPS];
    t_smp             r_dl_rd;
    t_smp             r_cf_rd;

    // ------------------------------------------------------------------
    // input decode
    // ------------------------------------------------------------------
    logic             w_in_acc;
    logic             w_load;
    logic             w_filt;
    logic [IW-1:0]    w_idx_ext;
    logic             w_idx_ok;
    logic [AW-1:0]    w_cf_addr;
    logic [AW-1:0]    w_wptr_inc;
    logic [AW-1:0]    w_rptr_dec;
    logic             w_out_free;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_load     = w_in_acc && (i_in.cmd == CMD_LOAD);
    assign w_filt     = w_in_acc && (i_in.cmd == CMD_FILTER);

    // loads beyond the tap count are dropped
    assign w_idx_ext  = IW'(i_in.coef_index);
    assign w_idx_ok   = (w_idx_ext < IW'(TAPS));
    assign w_cf_addr  = w_idx_ext[AW-1:0];

    // circular delay line: each sample is written at r_wptr, older ones sit at lower slots
    assign w_wptr_inc = (r_wptr == LAST) ? '0 : r_wptr + AW'(1);
    assign w_rptr_dec = (r_rptr == '0) ? LAST : r_rptr - AW'(1);

    assign w_out_free = !r_out_valid || o_out.ready;

    assign o_out.valid    = r_out_valid;
    assign o_out.filtered = r_filtered;

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_filt) begin
            m_dl[r_wptr] <= i_in.sample;
        end
        r_dl_rd <= m_dl[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (w_load && w_idx_ok) begin
            m_cf[w_cf_addr] <= i_in.coef_value;
        end
        r_cf_rd <= m_cf[r_k];
    end

    // ------------------------------------------------------------------
    // shared multiplier, registered; unwritten entries read as zero
    // ------------------------------------------------------------------
    t_smp w_mul_a;
    t_smp w_mul_b;

    assign w_mul_a = r_cf_rd_vld ? r_cf_rd : '0;
    assign w_mul_b = r_dl_rd_vld ? r_dl_rd : '0;

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_k         <= '0;
            r_issue     <= 1'b0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_dl_vld    <= '0;
            r_cf_vld    <= '0;
            r_dl_rd_vld <= 1'b0;
            r_cf_rd_vld <= 1'b0;
        end else begin
            // lookup flags follow the registered memory reads
            r_dl_rd_vld <= r_dl_vld[r_rptr];
            r_cf_rd_vld <= r_cf_vld[r_k];

            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_load && w_idx_ok) begin
                        r_cf_vld[w_cf_addr] <= 1'b1;
                    end
                    if (w_filt) begin
                        r_dl_vld[r_wptr] <= 1'b1;
                        r_rptr           <= r_wptr;
                        r_wptr           <= w_wptr_inc;
                        r_k              <= '0;
                        r_issue          <= 1'b1;
                        r_acc            <= '0;
                        r_state          <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_p1 <= r_issue;
                    r_p2 <= r_p1;
                    if (r_issue) begin
                        if (r_k == LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_k    <= r_k + AW'(1);
                            r_rptr <= w_rptr_dec;
                        end
                    end
                    if (r_p2) begin
                        r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                    end
                    // pipeline drained: sum complete
                    if (!r_issue && !r_p1 && !r_p2) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register can take the word
                    if (w_out_free) begin
                        r_filtered  <= r_acc;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
